// File: sv/fcm_pkg.sv
package fcm_pkg;

    localparam int NUM_CH     = 4;
    localparam int CH_W       = $clog2(NUM_CH);
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 24;
    localparam int TARGET_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int FRAC_W     = 22;
    localparam int WINDOW_LEN = 2048;
    localparam int WCNT_W     = $clog2(WINDOW_LEN + 1);

    // Blend coefficient for the new target: round(0.001 * 2^22).
    localparam int COEF_NEW   = 4194;

    // Shared multiplier operands are signed and one bit wider than the gain.
    localparam int MUL_W      = GAIN_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    // A product shifted down by the fraction bits.
    localparam int WIDE_W     = PROD_W - FRAC_W;
    // Running mix of four saturated samples.
    localparam int MIX_W      = SAMPLE_W + CH_W;

    localparam int IN_W       = NUM_CH * SAMPLE_W;
    localparam int OUT_W      = (NUM_CH + 1) * SAMPLE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN_MUL,
        ST_GAIN_UPD,
        ST_SAMP_MUL,
        ST_SAMP_UPD,
        ST_OUT
    } fcm_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [MUL_W-1:0] op_a;
        logic signed [MUL_W-1:0] op_b;
    } fcm_mul_req_t;

    // Clamp a wide signed value to the signed sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [WIDE_W-1:0] v
    );
        logic ovf;
        ovf = (v[WIDE_W-1:SAMPLE_W-1] != {(WIDE_W-SAMPLE_W+1){1'b0}}) &&
              (v[WIDE_W-1:SAMPLE_W-1] != {(WIDE_W-SAMPLE_W+1){1'b1}});
        if (!ovf) begin
            return v[SAMPLE_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

// File: sv/fcm_mul.sv
module fcm_mul
    import fcm_pkg::*;
(
    input  logic                     aclk,
    input  fcm_mul_req_t             req,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = $signed(req.op_a) * $signed(req.op_b);

    always_ff @(posedge aclk) begin
        if (req.start) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// File: sv/four_channel_mixer_with_peak_meters.sv
// Four-channel mixer with smoothed gains and windowed peak meters. Each input
// transaction carries one frame of four signed 24-bit samples; each produces
// exactly one output transaction with the saturated mix and the four held peak
// magnitudes. Every channel's gain glides toward its target (unsigned Q2.14,
// set through the configuration port, reset value 1.0) by one smoothing step
// per frame, starting from zero gain after reset. A single registered signed
// 25x25 multiplier serves all the multiplies: per channel it first forms the
// gain step (multiply, then update the gain) and then scales the sample
// (multiply, then add it to the mix and update the peak). After the four
// channels in turn, the result is handed to the output register, and the
// sequencer returns to idle, where the next frame is accepted. The output
// register decouples the result side: a new frame is accepted while the
// previous result still waits; only the hand-off state stalls if it is still
// untaken. Configuration writes are accepted on any cycle, but targets should
// only be changed while no frame is in flight. Writes to indexes above 3 are
// ignored. Peaks are held per channel and refresh every 2048 frames.
module four_channel_mixer_with_peak_meters
    import fcm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Input stream: one frame per transaction.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: sample_ch0, sample_ch1, sample_ch2, sample_ch3.
    input  logic [IN_W-1:0]      s_tdata,

    // Result stream: one result per frame.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: mix_sample, peak_ch0, peak_ch1, peak_ch2, peak_ch3.
    output logic [OUT_W-1:0]     m_tdata,

    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [TARGET_W-1:0]  cfg_wdata
);

    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(16384);
    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        {{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

    // Sequencer state.
    fcm_state_t state_reg, state_next;
    logic [CH_W-1:0] ch_reg;

    // Configuration and per-channel state.
    logic [TARGET_W-1:0] target_reg [NUM_CH];
    logic [GAIN_W-1:0]   gain_reg   [NUM_CH];
    logic [SAMPLE_W-1:0] rpeak_reg  [NUM_CH];
    logic [SAMPLE_W-1:0] hpeak_reg  [NUM_CH];
    logic [WCNT_W-1:0]   wcnt_reg   [NUM_CH];

    // Frame being worked on and its running mix.
    logic [IN_W-1:0]         samples_reg;
    logic signed [MIX_W-1:0] mix_reg;

    // Output register.
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    // Shared multiplier.
    fcm_mul_req_t             mul_req;
    logic signed [PROD_W-1:0] prod;

    fcm_mul u_mul (
        .aclk     (aclk),
        .req      (mul_req),
        .prod_reg (prod)
    );

    // Datapath around the multiplier.
    logic s_fire;
    logic out_load;
    logic signed [SAMPLE_W-1:0] x_cur;
    logic signed [MUL_W-1:0]    gain_diff;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [WIDE_W-1:0]   prod_shift;
    logic [GAIN_W-1:0]          gain_new;
    logic signed [SAMPLE_W-1:0] scaled;
    logic [SAMPLE_W-1:0]        mag;
    logic signed [MIX_W-1:0]    mix_next;
    logic signed [SAMPLE_W-1:0] mix_sat;

    assign s_fire    = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign x_cur = samples_reg[ch_reg*SAMPLE_W +: SAMPLE_W];

    // Gain glide: g*A + T*B equals g*2^22 + B*(T - g), since A + B = 2^22.
    assign gain_diff = $signed({1'b0, target_reg[ch_reg], 8'h00})
                     - $signed({1'b0, gain_reg[ch_reg]});

    // The rounded, floored product serves both the gain step and the
    // scaled sample, depending on which of them is in the product register.
    assign prod_rnd   = prod + ROUND_HALF;
    assign prod_shift = WIDE_W'(prod_rnd >>> FRAC_W);
    assign gain_new   = GAIN_W'($signed({{(WIDE_W-GAIN_W){1'b0}}, gain_reg[ch_reg]})
                                + prod_shift);

    assign scaled   = sat_sample(prod_shift);
    assign mag      = scaled[SAMPLE_W-1] ? (~scaled + SAMPLE_W'(1)) : scaled;
    assign mix_next = mix_reg + MIX_W'(scaled);
    assign mix_sat  = sat_sample(WIDE_W'(mix_reg));

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_GAIN_MUL;
                end
            end
            ST_GAIN_MUL: state_next = ST_GAIN_UPD;
            ST_GAIN_UPD: state_next = ST_SAMP_MUL;
            ST_SAMP_MUL: state_next = ST_SAMP_UPD;
            ST_SAMP_UPD: begin
                if (ch_reg == CH_W'(NUM_CH - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_GAIN_MUL;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: input handshake and multiplier requests.
    always_comb begin
        s_tready     = 1'b0;
        mul_req      = '0;
        unique case (state_reg) inside
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_GAIN_MUL: begin
                mul_req.start = 1'b1;
                mul_req.op_a  = gain_diff;
                mul_req.op_b  = MUL_W'(COEF_NEW);
            end
            ST_SAMP_MUL: begin
                mul_req.start = 1'b1;
                mul_req.op_a  = MUL_W'(x_cur);
                mul_req.op_b  = $signed({1'b0, gain_reg[ch_reg]});
            end
            ST_GAIN_UPD, ST_SAMP_UPD, ST_OUT: begin
                mul_req.start = 1'b0;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ch_reg       <= '0;
            mix_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                target_reg[c] <= TARGET_RESET;
                gain_reg[c]   <= '0;
                rpeak_reg[c]  <= '0;
                hpeak_reg[c]  <= '0;
                wcnt_reg[c]   <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid && (cfg_addr < CFG_IDX_W'(NUM_CH))) begin
                target_reg[cfg_addr[CH_W-1:0]] <= cfg_wdata;
            end

            if (s_fire) begin
                ch_reg  <= '0;
                mix_reg <= '0;
            end

            if (state_reg == ST_GAIN_UPD) begin
                gain_reg[ch_reg] <= gain_new;
            end

            if (state_reg == ST_SAMP_UPD) begin
                mix_reg <= mix_next;
                ch_reg  <= ch_reg + CH_W'(1);
                // Windowed peak: once the window is full, the old running peak
                // is held and a new window opens with the current magnitude.
                if (wcnt_reg[ch_reg] < WCNT_W'(WINDOW_LEN)) begin
                    if (mag > rpeak_reg[ch_reg]) begin
                        rpeak_reg[ch_reg] <= mag;
                    end
                    wcnt_reg[ch_reg] <= wcnt_reg[ch_reg] + WCNT_W'(1);
                end else begin
                    hpeak_reg[ch_reg] <= rpeak_reg[ch_reg];
                    rpeak_reg[ch_reg] <= mag;
                    wcnt_reg[ch_reg]  <= WCNT_W'(1);
                end
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            samples_reg <= s_tdata;
        end
        if (out_load) begin
            m_tdata_reg <= {hpeak_reg[3], hpeak_reg[2], hpeak_reg[1], hpeak_reg[0],
                            mix_sat};
        end
    end

endmodule
